@@ hdl/cpf_pkg.sv @@
// Package for the CRC-16 packet framer: shared constants, the burst
// descriptor passed from the front stage to the byte emitter, and the CRC step.
// No dependencies.
`timescale 1ns / 1ps

package cpf_pkg;

  localparam int unsigned MAX_PAYLOAD = 1022;
  localparam int unsigned LEN_W       = 10;
  localparam int unsigned CNT_W       = 3;

  localparam logic [7:0]  START_BYTE  = 8'hAA;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);

  // Item kinds on the input channel.
  localparam logic FUNC_HEADER  = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  // Byte counts of a burst before the CRC tail.
  localparam logic [CNT_W-1:0] HDR_BYTES = 3'd4;
  localparam logic [CNT_W-1:0] PAY_BYTES = 3'd1;
  localparam logic [CNT_W-1:0] CRC_BYTES = 3'd2;

  // One burst of framed bytes from a single input item.
  typedef struct packed {
    logic [3:0][7:0]  bytes;    // data bytes, index 0 sent first
    logic [CNT_W-1:0] nbytes;   // number of data bytes, 1 or 4
    logic             restart;  // first byte starts a new CRC
    logic             close;    // append CRC and end the packet
  } burst_t;

  // One byte of CRC-16/XMODEM, MSB first.
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/cpf_front.sv @@
// Front stage of the packet framer: tracks the open packet and turns each
// input beat into a registered burst descriptor. Depends on cpf_pkg.
`timescale 1ns / 1ps

module cpf_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_func,
  input  logic [7:0]                 in_packet_id,
  input  logic                       in_write_flag,
  input  logic [cpf_pkg::LEN_W-1:0]  in_pkt_len,
  input  logic [7:0]                 in_data_byte,
  output logic                       d_valid,
  input  logic                       d_ready,
  output cpf_pkg::burst_t            d_burst
);

  logic                      d_valid_r, d_valid_nxt;
  cpf_pkg::burst_t           d_burst_r, d_burst_nxt;
  logic [cpf_pkg::LEN_W-1:0] bytes_left_r, bytes_left_nxt;
  logic                      packet_open_r, packet_open_nxt;

  logic                      accept;
  logic [cpf_pkg::LEN_W-1:0] len_sat;
  logic [cpf_pkg::LEN_W-1:0] len_p1;
  logic [15:0]               flags;
  logic [cpf_pkg::LEN_W-1:0] left_dec;

  assign in_ready = !d_valid_r || d_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    len_sat = (in_pkt_len > cpf_pkg::LEN_MAX) ? cpf_pkg::LEN_MAX : in_pkt_len;
    len_p1  = len_sat + 1'b1;
    flags   = {len_p1, 5'b00000, in_write_flag};
    left_dec = bytes_left_r - 1'b1;

    d_valid_nxt     = d_valid_r && !d_ready;
    d_burst_nxt     = d_burst_r;
    bytes_left_nxt  = bytes_left_r;
    packet_open_nxt = packet_open_r;

    if (accept) begin
      if (in_func == cpf_pkg::FUNC_HEADER) begin
        d_valid_nxt             = 1'b1;
        d_burst_nxt.bytes[0]    = cpf_pkg::START_BYTE;
        d_burst_nxt.bytes[1]    = flags[7:0];
        d_burst_nxt.bytes[2]    = flags[15:8];
        d_burst_nxt.bytes[3]    = in_packet_id;
        d_burst_nxt.nbytes      = cpf_pkg::HDR_BYTES;
        d_burst_nxt.restart     = 1'b1;
        d_burst_nxt.close       = (len_sat == '0);
        bytes_left_nxt          = len_sat;
        packet_open_nxt         = (len_sat != '0);
      end else if (packet_open_r && bytes_left_r != '0) begin
        d_valid_nxt             = 1'b1;
        d_burst_nxt.bytes       = {24'h000000, in_data_byte};
        d_burst_nxt.nbytes      = cpf_pkg::PAY_BYTES;
        d_burst_nxt.restart     = 1'b0;
        d_burst_nxt.close       = (left_dec == '0);
        bytes_left_nxt          = left_dec;
        packet_open_nxt         = (left_dec != '0);
      end else begin
        // Payload with no packet open is dropped.
        d_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r     <= 1'b0;
      bytes_left_r  <= '0;
      packet_open_r <= 1'b0;
    end else begin
      d_valid_r     <= d_valid_nxt;
      bytes_left_r  <= bytes_left_nxt;
      packet_open_r <= packet_open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_burst_r <= d_burst_nxt;
  end

  assign d_valid = d_valid_r;
  assign d_burst = d_burst_r;

  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !packet_open_r |-> bytes_left_r == '0)
    else $error("closed packet still counts payload bytes");

  a_header_emits: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_func == cpf_pkg::FUNC_HEADER |=> d_valid_r && d_burst_r.restart)
    else $error("header beat produced no burst");

  a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    packet_open_r |-> bytes_left_r != '0)
    else $error("open packet with nothing left");

endmodule

@@ hdl/cpf_emit.sv @@
// Byte emitter of the packet framer: sends a burst one byte per beat, keeps
// the running CRC over sent bytes and appends the CRC tail. Depends on cpf_pkg.
`timescale 1ns / 1ps

module cpf_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            d_valid,
  output logic            d_ready,
  input  cpf_pkg::burst_t d_burst,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic                       busy_r, busy_nxt;
  logic [cpf_pkg::CNT_W-1:0]  idx_r, idx_nxt;
  logic [15:0]                crc_r, crc_nxt;
  cpf_pkg::burst_t            burst_r, burst_nxt;

  logic [cpf_pkg::CNT_W-1:0]  total;
  logic                       at_end;
  logic                       out_fire;
  logic                       is_data;
  logic [15:0]                crc_base;

  always_comb begin
    total    = burst_r.nbytes + (burst_r.close ? cpf_pkg::CRC_BYTES : 3'd0);
    at_end   = (idx_r == total - 1'b1);
    out_fire = busy_r && out_ready;
    is_data  = (idx_r < burst_r.nbytes);
    d_ready  = !busy_r || (out_ready && at_end);

    if (is_data) begin
      out_byte = burst_r.bytes[idx_r[1:0]];
    end else if (idx_r == burst_r.nbytes) begin
      out_byte = crc_r[7:0];
    end else begin
      out_byte = crc_r[15:8];
    end
    out_last  = busy_r && burst_r.close && at_end;
    out_valid = busy_r;

    crc_base  = (burst_r.restart && idx_r == '0) ? 16'h0000 : crc_r;

    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    burst_nxt = burst_r;

    if (out_fire) begin
      if (is_data) begin
        crc_nxt = cpf_pkg::crc_add(crc_base, out_byte);
      end else if (at_end) begin
        crc_nxt = 16'h0000;
      end
      if (at_end) begin
        busy_nxt = 1'b0;
        idx_nxt  = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end

    if (d_valid && d_ready) begin
      busy_nxt  = 1'b1;
      idx_nxt   = '0;
      burst_nxt = d_burst;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      crc_r  <= 16'h0000;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      crc_r  <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    burst_r <= burst_nxt;
  end

  a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> idx_r == '0)
    else $error("burst index not rewound after last byte");

  a_burst_size: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (burst_r.nbytes == cpf_pkg::PAY_BYTES || burst_r.nbytes == cpf_pkg::HDR_BYTES))
    else $error("burst with bad byte count");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r < total)
    else $error("burst index past end of burst");

endmodule

@@ hdl/crc16_packet_framer.sv @@
// Top level of the CRC-16 packet framer: front stage plus byte emitter.
// Depends on cpf_pkg, cpf_front and cpf_emit.
`timescale 1ns / 1ps

// The framer takes header and payload beats and sends the framed packet one
// byte per output beat. A header beat yields four bytes (start byte 0xAA, the
// flags word low byte first, the packet id), plus the two CRC bytes when its
// length is zero; a payload beat yields its byte, plus the two CRC bytes when
// it is the final one. The output port moves one byte per cycle while out_ready
// is high, and the input is stalled while a burst drains. The first byte of an
// accepted beat passes the registered front stage and then the emitter's burst
// register before it is offered at the output. Payload beats that arrive with
// no packet open are dropped without output, and a header arriving mid-packet
// abandons the old packet without a CRC. Lengths above 1022 are clamped to
// 1022.
module crc16_packet_framer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_func,
  input  logic [7:0]                 in_packet_id,
  input  logic                       in_write_flag,
  input  logic [cpf_pkg::LEN_W-1:0]  in_pkt_len,
  input  logic [7:0]                 in_data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_last
);

  // Burst descriptor handshake between the two stages.
  logic            d_valid;
  logic            d_ready;
  cpf_pkg::burst_t d_burst;

  // The front stage owns the packet state and registers one descriptor.
  cpf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_packet_id   (in_packet_id),
    .in_write_flag  (in_write_flag),
    .in_pkt_len     (in_pkt_len),
    .in_data_byte   (in_data_byte),
    .d_valid        (d_valid),
    .d_ready        (d_ready),
    .d_burst        (d_burst)
  );

  // The emitter takes a new descriptor on the cycle its last byte leaves,
  // so payload beats that do not close the packet stream at one per cycle while out_ready stays high.
  cpf_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .d_valid   (d_valid),
    .d_ready   (d_ready),
    .d_burst   (d_burst),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for crc16_packet_framer: directed packets, then
// random framed traffic under random sender gaps and receiver stalls.
// Depends on cpf_pkg and the framer RTL.
`timescale 1ns / 1ps

module testbench;

  // One input beat, with every field present whether the block uses it or not.
  typedef struct {
    logic                      func;
    logic [7:0]                packet_id;
    logic                      write_flag;
    logic [cpf_pkg::LEN_W-1:0] pkt_len;
    logic [7:0]                data_byte;
  } frame_req_t;

  // One output beat as the framer should produce it.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } framed_byte_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_func;
  logic [7:0]                in_packet_id;
  logic                      in_write_flag;
  logic [cpf_pkg::LEN_W-1:0] in_pkt_len;
  logic [7:0]                in_data_byte;
  logic                      out_valid;
  logic                      out_ready;
  logic [7:0]                out_byte;
  logic                      out_last;

  // Bytes the framer still owes us, oldest first.
  framed_byte_t expected_bytes[$];

  // Shadow copy of the framer's packet state.
  logic [15:0]               crc_acc;
  logic [cpf_pkg::LEN_W-1:0] bytes_owed;
  logic                      pkt_open;

  int error_count;
  int hold_cycles;   // when nonzero, the receiver refuses beats for this many cycles
  int burst_left;    // beats the sender may still offer back to back

  crc16_packet_framer u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_packet_id   (in_packet_id),
    .in_write_flag  (in_write_flag),
    .in_pkt_len     (in_pkt_len),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last       (out_last)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Packet predictor
  // ---------------------------------------------------------------------------

  // CRC-16/XMODEM, one message bit at a time, MSB first.
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      if (r[15] ^ b[k]) begin
        r = {r[14:0], 1'b0} ^ cpf_pkg::CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Queue a data byte of the packet and fold it into the running CRC.
  function automatic void emit_byte(logic [7:0] b);
    expected_bytes.push_back('{data: b, last: 1'b0});
    crc_acc = crc16_step(crc_acc, b);
  endfunction

  // The CRC tail goes out low byte first, and only its high byte is marked last.
  function automatic void close_packet();
    expected_bytes.push_back('{data: crc_acc[7:0], last: 1'b0});
    expected_bytes.push_back('{data: crc_acc[15:8], last: 1'b1});
    crc_acc    = '0;
    bytes_owed = '0;
    pkt_open   = 1'b0;
  endfunction

  // Work out the bytes that one accepted beat must produce.
  function automatic void frame_beat(frame_req_t r);
    logic [cpf_pkg::LEN_W-1:0] n;
    logic [15:0]               flags;
    if (r.func == cpf_pkg::FUNC_HEADER) begin
      // Oversized lengths saturate, in the flags word and in the byte count.
      n = (r.pkt_len > cpf_pkg::LEN_MAX) ? cpf_pkg::LEN_MAX : r.pkt_len;
      flags = {n + 10'd1, 5'd0, r.write_flag};
      // A header always restarts the CRC, even if a packet was left unfinished.
      crc_acc = '0;
      emit_byte(cpf_pkg::START_BYTE);
      emit_byte(flags[7:0]);
      emit_byte(flags[15:8]);
      emit_byte(r.packet_id);
      if (n == '0) begin
        close_packet();
      end else begin
        bytes_owed = n;
        pkt_open   = 1'b1;
      end
    end else if (pkt_open && bytes_owed != '0) begin
      emit_byte(r.data_byte);
      bytes_owed = bytes_owed - 1'b1;
      if (bytes_owed == '0) begin
        close_packet();
      end
    end
    // A payload beat with no packet open is dropped and produces nothing.
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders: unused fields carry random junk so the block must ignore it.
  // ---------------------------------------------------------------------------

  function automatic frame_req_t header_beat(logic [7:0] id, logic wr,
                                             logic [cpf_pkg::LEN_W-1:0] len);
    frame_req_t r;
    r.func        = cpf_pkg::FUNC_HEADER;
    r.packet_id   = id;
    r.write_flag  = wr;
    r.pkt_len     = len;
    r.data_byte   = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic frame_req_t payload_beat(logic [7:0] b);
    frame_req_t r;
    r.func        = cpf_pkg::FUNC_PAYLOAD;
    r.packet_id   = 8'($urandom_range(0, 255));
    r.write_flag  = 1'($urandom_range(0, 1));
    r.pkt_len     = cpf_pkg::LEN_W'($urandom_range(0, 1023));
    r.data_byte   = b;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers one beat and returns once it has been accepted. Beats come
  // in bursts; between bursts valid may drop for a random number of cycles. Some
  // bursts are long with no gap at all so the block also sees full rate input.
  // ---------------------------------------------------------------------------
  task automatic send_beat(frame_req_t r);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(30, 100);
      end else begin
        gap        = $urandom_range(0, 5);
        burst_left = $urandom_range(1, 12);
      end
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    // Payload changes only at the falling edge after the previous acceptance,
    // so valid stays high across back-to-back beats with a single assignment.
    @(negedge clk);
    in_valid       <= 1'b1;
    in_func        <= r.func;
    in_packet_id   <= r.packet_id;
    in_write_flag  <= r.write_flag;
    in_pkt_len     <= r.pkt_len;
    in_data_byte   <= r.data_byte;
    do @(posedge clk); while (!in_ready);
    frame_beat(r);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: a requested hold-off takes priority; otherwise out_ready follows
  // one of several stall patterns, switching pattern every so often.
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int mode_left;
    int phase;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        phase++;
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_ready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_ready <= (phase % 3 != 0);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every output beat is compared with the oldest expected byte.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    framed_byte_t exp_b;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output beat: out_byte %h out_last %b", out_byte, out_last);
        error_count++;
      end else begin
        exp_b = expected_bytes.pop_front();
        if (out_byte !== exp_b.data) begin
          $error("out_byte mismatch: expected %h, actual %h", exp_b.data, out_byte);
          error_count++;
        end
        if (out_last !== exp_b.last) begin
          $error("out_last mismatch: expected %b, actual %b", exp_b.last, out_last);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero-length headers close at once, with the CRC right after the id.
  task automatic test_zero_length();
    send_beat(header_beat(8'h00, 1'b0, '0));
    send_beat(header_beat(8'hFF, 1'b1, '0));
  endtask

  // A short packet whose bytes hit both extremes of the data field.
  task automatic test_short_packet();
    send_beat(header_beat(8'h5A, 1'b1, 10'd3));
    send_beat(payload_beat(8'h00));
    send_beat(payload_beat(8'hFF));
    send_beat(payload_beat(8'hA5));
    send_beat(header_beat(8'hC3, 1'b0, 10'd1));
    send_beat(payload_beat(8'h3C));
  endtask

  // Payload beats with no packet open are dropped, whatever their fields say.
  task automatic test_stray_payload();
    frame_req_t r;
    r.func        = cpf_pkg::FUNC_PAYLOAD;
    r.packet_id   = 8'hFF;
    r.write_flag  = 1'b1;
    r.pkt_len     = '1;
    r.data_byte   = 8'hFF;
    send_beat(r);
    r.packet_id   = 8'h00;
    r.write_flag  = 1'b0;
    r.pkt_len     = '0;
    r.data_byte   = 8'h00;
    send_beat(r);
  endtask

  // An oversized header is left unfinished; the next header abandons it and
  // must restart the CRC from zero.
  task automatic test_abandoned_packet();
    send_beat(header_beat(8'h81, 1'b1, 10'd1023));
    send_beat(payload_beat(8'h12));
    send_beat(header_beat(8'h7E, 1'b0, 10'd1022));
    send_beat(header_beat(8'h42, 1'b1, 10'd2));
    send_beat(payload_beat(8'h80));
    send_beat(payload_beat(8'h01));
  endtask

  // A saturated header is cut short by the next header; a longer packet then
  // closes normally, and one more payload beat after the close is dropped.
  task automatic test_long_packet();
    send_beat(header_beat(8'h99, 1'b0, 10'd1023));
    for (int i = 0; i < 8; i++) begin
      send_beat(payload_beat(8'($urandom_range(0, 255))));
    end
    send_beat(header_beat(8'h3A, 1'b1, 10'd64));
    for (int i = 0; i < 64; i++) begin
      send_beat(payload_beat(8'($urandom_range(0, 255))));
    end
    send_beat(payload_beat(8'h55));
  endtask

  // The receiver refuses beats for a long stretch while the sender keeps
  // offering a packet, so the framer fills and must stall its input.
  task automatic test_backpressure();
    hold_cycles = 300;
    send_beat(header_beat(8'h11, 1'b1, 10'd20));
    for (int i = 0; i < 20; i++) begin
      send_beat(payload_beat(8'($urandom_range(0, 255))));
    end
    send_beat(header_beat(8'h22, 1'b0, '0));
  endtask

  // Mostly well-formed packets with random content, mixed with abandoned
  // packets (full-range lengths) and stray payload beats.
  task automatic test_random_traffic();
    int counted;
    int plen;
    int nsend;
    counted = 0;
    while (counted < 295) begin
      case ($urandom_range(0, 9))
        0: begin
          // Noise: payload beats, dropped by the block when no packet is open.
          repeat ($urandom_range(1, 2)) begin
            counted++;
            send_beat(payload_beat(8'($urandom_range(0, 255))));
          end
        end
        1: begin
          // Broken packet: an arbitrary length, usually cut short by the next header.
          plen  = $urandom_range(0, 1023);
          nsend = (plen < 6) ? $urandom_range(0, plen) : $urandom_range(0, 6);
          send_beat(header_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                cpf_pkg::LEN_W'(plen)));
          counted++;
          repeat (nsend) begin
            send_beat(payload_beat(8'($urandom_range(0, 255))));
            counted++;
          end
        end
        default: begin
          plen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
          send_beat(header_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                cpf_pkg::LEN_W'(plen)));
          counted++;
          repeat (plen) begin
            send_beat(payload_beat(8'($urandom_range(0, 255))));
            counted++;
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = cpf_pkg::FUNC_HEADER;
    in_packet_id   = '0;
    in_write_flag  = 1'b0;
    in_pkt_len     = '0;
    in_data_byte   = '0;
    crc_acc        = '0;
    bytes_owed     = '0;
    pkt_open       = 1'b0;
    error_count    = 0;
    hold_cycles    = 0;
    burst_left     = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_zero_length();
    test_short_packet();
    test_stray_payload();
    test_abandoned_packet();
    test_backpressure();
    test_long_packet();
    test_random_traffic();

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain whatever is still owed, then watch a little longer for strays.
    while (expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legitimate run.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/cpf_pkg.sv
hdl/cpf_front.sv
hdl/cpf_emit.sv
hdl/crc16_packet_framer.sv
tb/testbench.sv
